// ===== rtl/core/range_sensor_frame_parser_top_assert.svh =====
// Assertion helpers for the range sensor frame parser.
// Each macro expects clk and rst to be visible where it is used.
`ifndef RANGE_SENSOR_FRAME_PARSER_TOP_ASSERT_SVH
`define RANGE_SENSOR_FRAME_PARSER_TOP_ASSERT_SVH

// Same-cycle implication.
`define RSFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsfp: same-cycle check failed");

// Next-cycle implication.
`define RSFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsfp: next-cycle check failed");

`endif

// ===== rtl/core/rsfp_pkg.sv =====
`default_nettype none
package rsfp_pkg;

  // Frame layout
  localparam logic [7:0] HEADER_BYTE = 8'h59;
  localparam logic [3:0] POS_PAYLOAD = 4'd2;
  localparam logic [3:0] POS_CHECK   = 4'd8;
  localparam int         STORE_LEN   = 5;  // reserved byte is not kept

  // Result status codes
  localparam logic [1:0] ST_CHK_ERR   = 2'd0;
  localparam logic [1:0] ST_OUT_RANGE = 2'd1;
  localparam logic [1:0] ST_VALID     = 2'd2;

  // Register map
  localparam int         ADDR_W               = 4;
  localparam logic [1:0] REG_STRENGTH_FLOOR   = 2'd0;
  localparam logic [1:0] REG_DISTANCE_FLOOR   = 2'd1;
  localparam logic [1:0] REG_DISTANCE_CEILING = 2'd2;

  localparam logic signed [15:0] STRENGTH_FLOOR_RST   = 16'sd20;
  localparam logic signed [15:0] DISTANCE_FLOOR_RST   = 16'sd1;
  localparam logic signed [15:0] DISTANCE_CEILING_RST = 16'sd5000;

  typedef struct packed {
    logic signed [15:0] strength_floor;
    logic signed [15:0] distance_floor;
    logic signed [15:0] distance_ceiling;
  } cfg_t;

  // Completed frame, handed from the framer to the range check
  typedef struct packed {
    logic               done;
    logic               chk_ok;
    logic signed [15:0] distance;
    logic signed [15:0] strength;
    logic [7:0]         mode;
  } frame_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_t;

  typedef struct packed {
    logic [1:0]         frame_status;
    logic signed [15:0] distance_cm;
    logic signed [15:0] signal_strength;
    logic [7:0]         range_mode;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/rsfp_stream_if.sv =====
`default_nettype none
// Byte channel from the serial receiver
interface rsfp_byte_if;
  import rsfp_pkg::*;
  logic valid;
  logic ready;
  rx_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// Decoded result channel
interface rsfp_result_if;
  import rsfp_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rsfp_cfg_regs.sv =====
`default_nettype none
module rsfp_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsfp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output rsfp_pkg::cfg_t              cfg
);
  import rsfp_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Register writes, access phase only
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strength_floor   <= STRENGTH_FLOOR_RST;
      cfg.distance_floor   <= DISTANCE_FLOOR_RST;
      cfg.distance_ceiling <= DISTANCE_CEILING_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_STRENGTH_FLOOR:   cfg.strength_floor   <= pwdata[15:0];
        REG_DISTANCE_FLOOR:   cfg.distance_floor   <= pwdata[15:0];
        REG_DISTANCE_CEILING: cfg.distance_ceiling <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Readback, sign-extended to the bus width
  always_comb begin
    case (reg_idx)
      REG_STRENGTH_FLOOR:   prdata = {{16{cfg.strength_floor[15]}}, cfg.strength_floor};
      REG_DISTANCE_FLOOR:   prdata = {{16{cfg.distance_floor[15]}}, cfg.distance_floor};
      REG_DISTANCE_CEILING: prdata = {{16{cfg.distance_ceiling[15]}}, cfg.distance_ceiling};
      default:              prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/rsfp_frame_fsm.sv =====
`default_nettype none
module rsfp_frame_fsm (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  output rsfp_pkg::frame_t frame
);
  import rsfp_pkg::*;

  logic [3:0] pos;
  logic [3:0] pos_next;
  logic [7:0] sum;
  logic [7:0] sum_next;
  logic [7:0] sum_base;
  logic       at_check;
  logic [7:0] pay [STORE_LEN];

  // Next position and running checksum
  always_comb begin
    sum_base = (pos == 4'd0) ? 8'd0 : sum;
    pos_next = pos;
    sum_next = sum;
    at_check = 1'b0;
    if (pos < POS_PAYLOAD) begin
      if (rx_byte == HEADER_BYTE) begin
        pos_next = pos + 4'd1;
        sum_next = sum_base + rx_byte;
      end else begin
        // broken header: drop the byte and hunt again
        pos_next = 4'd0;
      end
    end else if (pos < POS_CHECK) begin
      pos_next = pos + 4'd1;
      sum_next = sum + rx_byte;
    end else begin
      pos_next = 4'd0;
      at_check = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 4'd0;
      sum <= 8'd0;
    end else if (accept) begin
      pos <= pos_next;
      sum <= sum_next;
    end
  end

  // Payload capture, one register per byte slot
  for (genvar i = 0; i < STORE_LEN; i++) begin : g_pay
    always_ff @(posedge clk) begin
      if (accept && pos == POS_PAYLOAD + 4'(i)) begin
        pay[i] <= rx_byte;
      end
    end
  end

  // Frame complete on the checksum byte
  assign frame.done     = accept && at_check;
  assign frame.chk_ok   = (sum == rx_byte);
  assign frame.distance = {pay[1], pay[0]};
  assign frame.strength = {pay[3], pay[2]};
  assign frame.mode     = pay[4];

endmodule
`default_nettype wire

// ===== rtl/core/rsfp_range_check.sv =====
`default_nettype none
module rsfp_range_check (
  input  logic              clk,
  input  logic              rst,
  input  rsfp_pkg::frame_t  frame,
  input  rsfp_pkg::cfg_t    cfg,
  input  logic              out_ready,
  output logic              out_valid,
  output rsfp_pkg::result_t result
);
  import rsfp_pkg::*;

  logic    in_window;
  result_t result_next;

  // Strict signed window test
  assign in_window = (frame.strength > cfg.strength_floor)
                  && (frame.distance > cfg.distance_floor)
                  && (frame.distance < cfg.distance_ceiling);

  always_comb begin
    if (!frame.chk_ok) begin
      result_next.frame_status    = ST_CHK_ERR;
      result_next.distance_cm     = 16'sd0;
      result_next.signal_strength = 16'sd0;
      result_next.range_mode      = 8'd0;
    end else begin
      result_next.frame_status    = in_window ? ST_VALID : ST_OUT_RANGE;
      result_next.distance_cm     = frame.distance;
      result_next.signal_strength = frame.strength;
      result_next.range_mode      = frame.mode;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.done) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/range_sensor_frame_parser_top.sv =====
// A result is valid in the cycle after its checksum byte beat is accepted.
// Throughput: one byte beat per cycle; the output register is the only stage.
// The input stalls only while a result waits in the output register unclaimed.
// Reset: clears the frame position, checksum, output valid, and loads the
// window registers with strength floor 20, distance floor 1, ceiling 5000.
`default_nettype none
`include "range_sensor_frame_parser_top_assert.svh"
module range_sensor_frame_parser_top (
  input  logic                        clk,
  input  logic                        rst,
  rsfp_byte_if.sink                   rx,
  rsfp_result_if.source               res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsfp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rsfp_pkg::*;

  logic   accept;
  cfg_t   cfg;
  frame_t frame;
  logic   chk_err_beat;

  assign pready   = 1'b1;
  assign rx.ready = !res.valid || res.ready;
  assign accept   = rx.valid && rx.ready;

  rsfp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  rsfp_frame_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.payload.rx_byte),
    .frame   (frame)
  );

  rsfp_range_check u_chk (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .cfg       (cfg),
    .out_ready (res.ready),
    .out_valid (res.valid),
    .result    (res.payload)
  );

  assign chk_err_beat = res.valid && (res.payload.frame_status == ST_CHK_ERR);

  // Checks; the low 40 payload bits are distance, strength and mode
  `RSFP_ASSERT_IMP(a_done_on_beat, frame.done, rx.valid && rx.ready)
  `RSFP_ASSERT_NXT(a_done_gives_result, frame.done, res.valid)
  `RSFP_ASSERT_IMP(a_status_legal, res.valid, res.payload.frame_status <= ST_VALID)
  `RSFP_ASSERT_IMP(a_chk_err_zero, chk_err_beat, res.payload[39:0] == '0)

endmodule
`default_nettype wire
